>>> rtl/w2s_pkg.sv
package w2s_pkg;

	// Output coordinate width (signed Q16.16 at the default).
	localparam int COORD_WIDTH = 32;

	// Widths of the internal datapath.
	localparam int PROD_W    = 48;   // product after the Q16.16 shift
	localparam int CLIP_W    = 50;   // clip-space sum
	localparam int DIV_STEPS = 47;   // fraction and integer bits below the cap
	localparam int NDC_W     = 49;   // signed ndc, cap included
	localparam int MUL_W     = 65;   // ndc times viewport factor
	localparam int SUM_W     = 66;   // viewport result before clamping

	// Item kinds carried on the input tuser.
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_POINT = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_MIN_W  = 2'd2;

	typedef struct packed {
		logic [CLIP_W-1:0]    rem;
		logic [DIV_STEPS-1:0] quo;
		logic [DIV_STEPS-1:0] dvd;
		logic                 cap;
		logic                 neg;
	} div_lane_t;

	typedef struct packed {
		div_lane_t [2:0]   lane;
		logic [CLIP_W-1:0] w;
		logic              vis;
	} div_stage_t;

endpackage

>>> rtl/world_to_screen_projection.sv
// World-to-screen projection with a loadable 4x4 matrix.
// Input items arrive on the s_ channel. s_tuser selects the kind: 0 loads one
// matrix coefficient (coef_index, coef_value), 1 projects a world point given
// in signed Q16.16. A load produces no output item; a point produces exactly
// one item on the m_ channel carrying screen x, screen y and depth in signed
// Q16.16 plus the visible and saturated flags.
// The cfg_ port writes the viewport width, height and minimum clip w; the user
// must write it only while no point is in flight, and the block does not enforce it.
// A point passes through one multiply stage, one sum stage, one magnitude stage,
// 48 stages of the restoring divider (a cap and seed stage, then one quotient
// bit per stage, three lanes sharing clip w), one sign stage, one viewport
// multiply stage and the output register. The divider sets the pipeline depth.
// Throughput is one item per cycle. The whole pipeline advances together: it
// stalls only when the output register holds an item that the receiver does
// not take, and then nothing is lost or repeated. Empty stages still let new
// items in as long as the output register is free.
// Reset clears the matrix to zero, restores the register defaults
// (1920 x 1080, minimum w of 0.1) and empties the pipeline.
module world_to_screen_projection (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [135:0] s_tdata,   // coef_index, coef_value, world_x, world_y, world_z, pad
	input  logic         s_tuser,   // op
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,   // screen_x, screen_y, depth
	output logic [1:0]   m_tuser,   // visible, saturated
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [30:0]  cfg_data
);
	import w2s_pkg::*;

	localparam logic signed [SUM_W-1:0] SAT_HI =
		(SUM_W'(1) <<< (COORD_WIDTH - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);
	localparam int NSTG = DIV_STEPS + 1;

	// Configuration and matrix store.
	logic [13:0] width_q, height_q;
	logic [30:0] min_w_q;
	logic [31:0] mat_q [16];

	logic en, in_acc;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 14'd1920;
			height_q <= 14'd1080;
			min_w_q  <= 31'd6554;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[13:0];
				REG_HEIGHT: height_q <= cfg_data[13:0];
				REG_MIN_W:  min_w_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) mat_q[i] <= '0;
		end else if (in_acc && s_tuser == OP_LOAD) begin
			mat_q[s_tdata[3:0]] <= s_tdata[35:4];
		end
	end

	// Stage 1: twelve products, each floored back to Q16.16.
	logic [31:0]            pt [3];
	logic signed [63:0]     prod_c [4][3];
	logic signed [PROD_W-1:0] prod_s1 [4][3];
	logic [31:0]            tran_s1 [4];
	logic                   v_s1;

	assign pt[0] = s_tdata[67:36];
	assign pt[1] = s_tdata[99:68];
	assign pt[2] = s_tdata[131:100];

	always_comb begin
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 3; c++)
				prod_c[r][c] = $signed(mat_q[r*4+c]) * $signed(pt[c]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				tran_s1[r] <= mat_q[r*4+3];
				for (int c = 0; c < 3; c++) prod_s1[r][c] <= prod_c[r][c][63:16];
			end
		end
	end

	// Stage 2: the four clip-space sums.
	logic signed [CLIP_W-1:0] clip_s2 [4];
	logic                     v_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++)
				clip_s2[r] <= CLIP_W'(prod_s1[r][0]) + CLIP_W'(prod_s1[r][1])
				            + CLIP_W'(prod_s1[r][2]) + CLIP_W'($signed(tran_s1[r]));
		end
	end

	// Stage 3: visibility test and magnitudes for the divider.
	logic [CLIP_W-1:0] mag_s3 [3];
	logic [2:0]        neg_s3;
	logic [CLIP_W-1:0] w_s3;
	logic              vis_s3, v_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s3[i] <= clip_s2[i][CLIP_W-1];
				mag_s3[i] <= clip_s2[i][CLIP_W-1] ? CLIP_W'(-clip_s2[i])
				                                  : CLIP_W'(clip_s2[i]);
			end
			w_s3   <= clip_s2[3];
			vis_s3 <= (clip_s2[3] >= $signed({{(CLIP_W-31){1'b0}}, min_w_q}))
			          && (clip_s2[3] != '0);
		end
	end

	// Divider: stage 0 checks the cap and seeds the remainder with the
	// integer bits from 2^31 up; each later stage retires one quotient bit.
	div_stage_t dv   [NSTG];
	logic       dv_v [NSTG];

	always_ff @(posedge clk) begin
		if (en) begin
			dv[0].w   <= w_s3;
			dv[0].vis <= vis_s3;
			for (int i = 0; i < 3; i++) begin
				dv[0].lane[i].rem <= CLIP_W'(mag_s3[i][CLIP_W-1:31]);
				dv[0].lane[i].dvd <= {mag_s3[i][30:0], 16'd0};
				dv[0].lane[i].quo <= '0;
				dv[0].lane[i].cap <= CLIP_W'(mag_s3[i][CLIP_W-1:31]) >= w_s3;
				dv[0].lane[i].neg <= neg_s3[i];
			end
		end
	end

	for (genvar k = 1; k < NSTG; k++) begin : g_div
		div_stage_t nxt;
		always_comb begin
			logic [CLIP_W:0] t;
			logic            ge;
			nxt = dv[k-1];
			for (int i = 0; i < 3; i++) begin
				t  = {dv[k-1].lane[i].rem, dv[k-1].lane[i].dvd[DIV_STEPS-1]};
				ge = t >= {1'b0, dv[k-1].w};
				if (ge) t = t - {1'b0, dv[k-1].w};
				nxt.lane[i].rem = t[CLIP_W-1:0];
				nxt.lane[i].quo = {dv[k-1].lane[i].quo[DIV_STEPS-2:0], ge};
				nxt.lane[i].dvd = {dv[k-1].lane[i].dvd[DIV_STEPS-2:0], 1'b0};
			end
		end
		always_ff @(posedge clk) begin
			if (en) dv[k] <= nxt;
		end
	end

	// Stage 4: cap and sign applied.
	logic signed [NDC_W-1:0] ndc_s4 [3];
	logic                    vis_s4, v_s4;

	always_ff @(posedge clk) begin
		logic [NDC_W-1:0] n;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				n = dv[NSTG-1].lane[i].cap ? (NDC_W'(1) << DIV_STEPS)
				                           : NDC_W'(dv[NSTG-1].lane[i].quo);
				ndc_s4[i] <= dv[NSTG-1].lane[i].neg ? -n : n;
			end
			vis_s4 <= dv[NSTG-1].vis;
		end
	end

	// Stage 5: viewport scale factors (W+2) and (2-H).
	logic signed [15:0]       fx, fy;
	logic signed [MUL_W-1:0]  mx_s5, my_s5;
	logic signed [NDC_W-1:0]  nz_s5;
	logic                     vis_s5, v_s5;

	assign fx = $signed({2'b00, width_q}) + 16'sd2;
	assign fy = 16'sd2 - $signed({2'b00, height_q});

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s5  <= ndc_s4[0] * fx;
			my_s5  <= ndc_s4[1] * fy;
			nz_s5  <= ndc_s4[2];
			vis_s5 <= vis_s4;
		end
	end

	// Output stage: halve, offset by the viewport center, clamp.
	logic signed [SUM_W-1:0] sx_c, sy_c, sz_c;
	logic [31:0]             ox, oy, oz;
	logic                    fl_x, fl_y, fl_z;

	assign sx_c = SUM_W'(mx_s5 >>> 1) + $signed({{(SUM_W-29){1'b0}}, width_q, 15'd0});
	assign sy_c = SUM_W'(my_s5 >>> 1) + $signed({{(SUM_W-29){1'b0}}, height_q, 15'd0});
	assign sz_c = SUM_W'(nz_s5);

	always_comb begin
		fl_x = (sx_c > SAT_HI) || (sx_c < SAT_LO);
		fl_y = (sy_c > SAT_HI) || (sy_c < SAT_LO);
		fl_z = (sz_c > SAT_HI) || (sz_c < SAT_LO);
		ox = (sx_c > SAT_HI) ? SAT_HI[31:0] : (sx_c < SAT_LO) ? SAT_LO[31:0] : sx_c[31:0];
		oy = (sy_c > SAT_HI) ? SAT_HI[31:0] : (sy_c < SAT_LO) ? SAT_LO[31:0] : sy_c[31:0];
		oz = (sz_c > SAT_HI) ? SAT_HI[31:0] : (sz_c < SAT_LO) ? SAT_LO[31:0] : sz_c[31:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= vis_s5 ? {oz, oy, ox} : '0;
			m_tuser <= {vis_s5 && (fl_x || fl_y || fl_z), vis_s5};
		end
	end

	// Valid bits travel with the items; loads never enter the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			m_tvalid <= 1'b0;
			for (int k = 0; k < NSTG; k++) dv_v[k] <= 1'b0;
		end else if (en) begin
			v_s1    <= in_acc && s_tuser == OP_POINT;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			dv_v[0] <= v_s3;
			for (int k = 1; k < NSTG; k++) dv_v[k] <= dv_v[k-1];
			v_s4     <= dv_v[NSTG-1];
			v_s5     <= v_s4;
			m_tvalid <= v_s5;
		end
	end

	// A hidden point carries zero coordinates and no saturation flag.
	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
		else $error("hidden point with nonzero payload");

	// A coefficient load never becomes a pipeline item.
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && s_tuser == OP_LOAD |=> !v_s1)
		else $error("load entered the pipeline");

	// A stalled pipeline keeps its items in place.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s5) && $stable(v_s1) && $stable(dv_v[NSTG-1]))
		else $error("pipeline moved during a stall");

endmodule

>>> tb/world_to_screen_checker.sv
`timescale 1ns / 100ps

// Watches the stream channels and the register port of the projection block,
// predicts each point result and compares it with what leaves the block.
module world_to_screen_checker
	import w2s_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [135:0] s_tdata,
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [95:0]  m_tdata,
	input  logic [1:0]   m_tuser,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [30:0]  cfg_data,
	output int           fails,
	output int           pending
);

	typedef struct {
		bit                 vis;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] dz;
		bit                 sat;
	} screen_point_t;

	logic [13:0]        view_w;
	logic [13:0]        view_h;
	logic [30:0]        clip_w_floor;
	logic signed [31:0] coefs [16];
	screen_point_t      points_due [$];

	function automatic longint row_dot(input int row, input longint p [3]);
		longint acc;
		acc = longint'(coefs[row * 4 + 3]);
		for (int c = 0; c < 3; c++)
			acc += (longint'(coefs[row * 4 + c]) * p[c]) >>> 16;
		return acc;
	endfunction

	// Q16.16 quotient of magnitudes, truncated toward zero, capped at 2^47.
	function automatic longint ndc_divide(input longint num, input longint den);
		logic [127:0] mag;
		logic [127:0] quo;
		mag = (num < 0) ? 128'(-num) : 128'(num);
		if (mag / 128'(den) >= 128'h8000_0000)
			quo = 128'(1) << 47;
		else
			quo = (mag << 16) / 128'(den);
		return (num < 0) ? -longint'(quo) : longint'(quo);
	endfunction

	function automatic longint clamp32(input longint v, inout bit sat);
		if (v > 64'sh7FFF_FFFF) begin
			sat = 1'b1;
			return 64'sh7FFF_FFFF;
		end
		if (v < -64'sh8000_0000) begin
			sat = 1'b1;
			return -64'sh8000_0000;
		end
		return v;
	endfunction

	function automatic screen_point_t project_point(input logic [31:0] x, y, z);
		screen_point_t r;
		longint p [3];
		longint clip [4];
		longint nx, ny, nz, sx, sy;
		bit sat;
		p[0] = longint'(signed'(x));
		p[1] = longint'(signed'(y));
		p[2] = longint'(signed'(z));
		for (int i = 0; i < 4; i++)
			clip[i] = row_dot(i, p);
		r = '{1'b0, '0, '0, '0, 1'b0};
		// A clip w of exactly zero never divides, even with a zero floor.
		if (clip[3] < longint'(clip_w_floor) || clip[3] == 0)
			return r;
		nx = ndc_divide(clip[0], clip[3]);
		ny = ndc_divide(clip[1], clip[3]);
		nz = ndc_divide(clip[2], clip[3]);
		sx = ((nx * (longint'(view_w) + 2)) >>> 1) + (longint'(view_w) << 15);
		sy = ((ny * (2 - longint'(view_h))) >>> 1) + (longint'(view_h) << 15);
		sat = 1'b0;
		r.vis = 1'b1;
		r.sx = 32'(clamp32(sx, sat));
		r.sy = 32'(clamp32(sy, sat));
		r.dz = 32'(clamp32(nz, sat));
		r.sat = sat;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		screen_point_t due;
		int errs;
		if (!arst_n) begin
			view_w <= 14'd1920;
			view_h <= 14'd1080;
			clip_w_floor <= 31'd6554;
			for (int i = 0; i < 16; i++)
				coefs[i] <= '0;
			points_due.delete();
			fails <= 0;
			pending <= 0;
		end else begin
			errs = 0;
			// Results leave before the item accepted at the same edge enters.
			if (m_tvalid && m_tready) begin
				if (points_due.size() == 0) begin
					$error("result item with no point outstanding");
					errs++;
				end else begin
					due = points_due.pop_front();
					if (m_tuser[0] !== due.vis) begin
						$error("visible: expected %0d, got %0d", due.vis, m_tuser[0]);
						errs++;
					end
					if (m_tdata[31:0] !== due.sx) begin
						$error("screen_x: expected %0d, got %0d", due.sx,
							$signed(m_tdata[31:0]));
						errs++;
					end
					if (m_tdata[63:32] !== due.sy) begin
						$error("screen_y: expected %0d, got %0d", due.sy,
							$signed(m_tdata[63:32]));
						errs++;
					end
					if (m_tdata[95:64] !== due.dz) begin
						$error("depth: expected %0d, got %0d", due.dz,
							$signed(m_tdata[95:64]));
						errs++;
					end
					if (m_tuser[1] !== due.sat) begin
						$error("saturated: expected %0d, got %0d", due.sat, m_tuser[1]);
						errs++;
					end
				end
			end
			fails <= fails + errs;
			if (s_tvalid && s_tready) begin
				if (s_tuser == OP_LOAD)
					coefs[s_tdata[3:0]] <= s_tdata[35:4];
				else
					points_due.push_back(project_point(s_tdata[67:36], s_tdata[99:68],
						s_tdata[131:100]));
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_WIDTH: view_w <= cfg_data[13:0];
					REG_HEIGHT: view_h <= cfg_data[13:0];
					REG_MIN_W: clip_w_floor <= cfg_data;
					default: ;
				endcase
			end
			pending <= points_due.size();
		end
	end

endmodule

>>> tb/tb_world_to_screen_projection.sv
`timescale 1ns / 100ps

// Top of the projection testbench. It makes stimulus, paces both stream sides
// and gives the verdict; all prediction and comparison lives in the checker.
module tb_world_to_screen_projection;
	import w2s_pkg::*;

	// Cycles with no item moving on either side before the run is declared hung.
	// The slowest legal stretch is a sender gap plus a trip through the pipeline, a
	// receiver stall and the closing wait, so this leaves a wide margin.
	localparam int HANG_LIMIT = 4000;
	// The pipeline is 54 stages deep; settle a little longer than that.
	localparam int SETTLE = 70;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [135:0] s_tdata = '0;
	logic         s_tuser = OP_LOAD;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [95:0]  m_tdata;
	logic [1:0]   m_tuser;
	logic         cfg_we = 1'b0;
	logic [1:0]   cfg_index = REG_WIDTH;
	logic [30:0]  cfg_data = '0;

	int fails;
	int pending;
	int burst_left = 0;
	int stall_mode = 0;
	int quiet_cycles = 0;
	int unsigned rx_tick = 0;

	always #10 clk = ~clk;

	world_to_screen_projection dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	world_to_screen_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fails(fails), .pending(pending)
	);

	// The receiver follows its own pattern: always ready, random stalls,
	// a fixed duty cycle or coin flips, chosen per phase.
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= (rx_tick % 7 < 4);
			default: m_tready <= 1'($urandom_range(0, 1));
		endcase
	end

	// Hang detector: counts cycles in which no item is accepted on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Presents one item and holds it until the block takes it. The sender runs
	// in bursts; between bursts valid drops and the sender waits before raising
	// it again, so it is never lowered and raised within the same step.
	task automatic send_item(input logic op, input logic [3:0] idx,
		input logic [31:0] coef, input logic [31:0] x, y, z);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 60);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {4'b0, z, y, x, coef, idx};
		@(posedge clk iff s_tready);
	endtask

	task automatic load_coef(input logic [3:0] idx, input logic [31:0] coef);
		send_item(OP_LOAD, idx, coef, $urandom, $urandom, $urandom);
	endtask

	task automatic project(input logic [31:0] x, y, z);
		send_item(OP_POINT, 4'($urandom), $urandom, x, y, z);
	endtask

	// Lowers valid and waits until every point has come back, then lets the
	// pipeline settle so registers can be written while it is idle.
	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// One write, then a quiet wait so the enable never moves twice in a step.
	task automatic write_reg(input logic [1:0] idx, input logic [30:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Coefficients mostly of modest size, now and then any 32-bit value.
	function automatic logic [31:0] rand_coef();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1, 2: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
			default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
		endcase
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
			default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
		endcase
	endfunction

	// A fresh matrix with random content. The w row usually gets a positive
	// translation large enough that most points come out visible.
	task automatic load_matrix();
		for (int i = 0; i < 16; i++) begin
			if (i == 15 && $urandom_range(0, 4) != 0)
				load_coef(4'(i), $urandom_range(32'h0000_8000, 32'h0040_0000));
			else if (i >= 12 && i < 15 && $urandom_range(0, 1) == 0)
				load_coef(4'(i), $urandom_range(0, 32'h0000_2000) - 32'h0000_1000);
			else
				load_coef(4'(i), rand_coef());
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. With the matrix still zero the clip w is zero, which is
		// below the default floor, and stays invisible even with a floor of zero.
		project(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
		drain();
		write_reg(REG_MIN_W, 31'd0);
		write_reg(REG_WIDTH, 31'd0);
		write_reg(REG_HEIGHT, 31'd16383);
		project(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
		// Identity-like matrix with w = 1.0: ndc equals the point itself.
		load_coef(4'd0, 32'h0001_0000);
		load_coef(4'd5, 32'h0001_0000);
		load_coef(4'd10, 32'h0001_0000);
		load_coef(4'd15, 32'h0001_0000);
		project(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000);
		project(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		project(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		// Tiny w makes the quotients large and drives the outputs into saturation.
		load_coef(4'd15, 32'h0000_0001);
		project(32'h0010_0000, 32'hFFF0_0000, 32'h7FFF_FFFF);
		// Negative w is never visible.
		load_coef(4'd15, 32'hFFFF_0000);
		project(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		// Extreme translation coefficients and the most negative point.
		load_coef(4'd3, 32'h8000_0000);
		load_coef(4'd7, 32'h7FFF_FFFF);
		load_coef(4'd15, 32'h7FFF_FFFF);
		project(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		drain();
		write_reg(REG_WIDTH, 31'd1);
		write_reg(REG_HEIGHT, 31'd1);
		write_reg(REG_MIN_W, 31'h7FFF_FFFF);
		project(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		drain();

		// Random phases: new settings and receiver pattern each time, a full
		// matrix load, then points with the odd stray load mixed in.
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin
					write_reg(REG_WIDTH, 31'd8192);
					write_reg(REG_HEIGHT, 31'd8192);
					write_reg(REG_MIN_W, 31'd0);
				end
				1: begin
					write_reg(REG_WIDTH, 31'd1920);
					write_reg(REG_HEIGHT, 31'd1080);
					write_reg(REG_MIN_W, 31'd6554);
				end
				default: begin
					write_reg(REG_WIDTH, 31'($urandom_range(1, 8192)));
					write_reg(REG_HEIGHT, 31'($urandom_range(0, 16383)));
					write_reg(REG_MIN_W, ($urandom_range(0, 3) == 0) ? 31'($urandom) :
						31'($urandom_range(0, 32'h0002_0000)));
				end
			endcase
			stall_mode <= phase % 4;
			load_matrix();
			for (int n = 0; n < 140; n++) begin
				if ($urandom_range(0, 19) == 0)
					load_coef(4'($urandom), rand_coef());
				else
					project(rand_coord(), rand_coord(), rand_coord());
			end
			drain();
		end

		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
